[rtl/gha_pkg.sv]
`default_nettype none

package gha_pkg;

  // Slot count follows from the index width of a handle.
  localparam int unsigned IDX_W = 8;
  localparam int unsigned SLOTS = 1 << IDX_W;
  localparam int unsigned GEN_W = 16;
  localparam int unsigned CNT_W = IDX_W + 1;
  localparam int unsigned MODE_W = 2;
  localparam int unsigned STATUS_W = 2;

  localparam logic [MODE_W-1:0] MODE_CREATE  = 2'd0;
  localparam logic [MODE_W-1:0] MODE_DESTROY = 2'd1;
  localparam logic [MODE_W-1:0] MODE_CHECK   = 2'd2;

  localparam logic [STATUS_W-1:0] STATUS_DONE = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_FULL = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_DEAD = 2'd2;

  // A free-stack entry carries the slot and the generation it will reissue.
  typedef struct packed {
    logic [IDX_W-1:0] idx;
    logic [GEN_W-1:0] gen;
  } stack_entry_t;

  localparam int unsigned STK_W = $bits(stack_entry_t);

  // A generation-table entry carries the live flag of the slot and its current stamp.
  typedef struct packed {
    logic             live;
    logic [GEN_W-1:0] gen;
  } slot_entry_t;

  localparam int unsigned SLOT_W = $bits(slot_entry_t);

  typedef enum logic {
    ST_IDLE,
    ST_EXEC
  } state_e;

endpackage

`default_nettype wire

[rtl/gha_ram.sv]
`default_nettype none

module gha_ram #(
  parameter int unsigned DEPTH = 256,
  parameter int unsigned WIDTH = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // Read data is registered and holds until the next read.
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem[raddr_i];
    end
  end

endmodule

`default_nettype wire

[rtl/generational_handle_allocator_core.sv]
// A request transfers in the idle state, which also issues both RAM reads; in the execute
// state its result is loaded into the output register once that register can take it.
// A new request is taken only back in the idle state, because of the read-modify-write of
// the generation table and free stack, each a registered RAM read, then written back.
// Reset clears the counters and the handshake state at once; the two RAMs are not
// cleared, and no unwritten entry ever decides a result.
`default_nettype none

module generational_handle_allocator_core (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           in_valid_i,
  output logic                                in_stall_o,
  input  wire logic [gha_pkg::MODE_W-1:0]     mode_i,
  input  wire logic [gha_pkg::IDX_W-1:0]      handle_index_i,
  input  wire logic [gha_pkg::GEN_W-1:0]      handle_generation_i,
  output logic                                out_valid_o,
  input  wire logic                           out_stall_i,
  output logic      [gha_pkg::STATUS_W-1:0]   status_o,
  output logic      [gha_pkg::IDX_W-1:0]      out_index_o,
  output logic      [gha_pkg::GEN_W-1:0]      out_generation_o,
  output logic                                alive_o,
  output logic      [gha_pkg::CNT_W-1:0]      live_count_o
);

  import gha_pkg::*;

  // Handshake and sequencing.
  state_e state_q, state_d;
  logic   in_xfer;
  logic   exec_go;

  // Captured request.
  logic [MODE_W-1:0] req_mode_q;
  logic [IDX_W-1:0]  req_idx_q;
  logic [GEN_W-1:0]  req_gen_q;

  // Allocator counters.
  logic [CNT_W-1:0] free_depth_q, free_depth_d;
  logic [CNT_W-1:0] high_water_q, high_water_d;
  logic [CNT_W-1:0] live_total_q, live_total_d;

  // RAM ports.
  logic              gen_we;
  logic [IDX_W-1:0]  gen_waddr;
  slot_entry_t       gen_wdata;
  logic [SLOT_W-1:0] gen_rdata;
  slot_entry_t       slot_rd;
  logic              stk_we;
  logic [IDX_W-1:0]  stk_waddr;
  stack_entry_t      stk_wdata;
  logic [STK_W-1:0]  stk_rdata;
  stack_entry_t      stk_top;
  logic [IDX_W-1:0]  stk_raddr;

  // Result computed in the execute cycle.
  logic [STATUS_W-1:0] res_status;
  logic [IDX_W-1:0]    res_index;
  logic [GEN_W-1:0]    res_gen;
  logic                res_alive;
  logic                hit;
  logic [GEN_W-1:0]    gen_next;

  // Output register.
  logic                out_valid_q, out_valid_d;
  logic [STATUS_W-1:0] status_q;
  logic [IDX_W-1:0]    out_index_q;
  logic [GEN_W-1:0]    out_gen_q;
  logic                alive_q;
  logic [CNT_W-1:0]    live_count_q;

  // The generation table holds the live flag and the current stamp of every slot below
  // the high-water mark.
  gha_ram #(
    .DEPTH(SLOTS),
    .WIDTH(SLOT_W)
  ) u_gen_ram (
    .clk_i  (clk_i),
    .we_i   (gen_we),
    .waddr_i(gen_waddr),
    .wdata_i(gen_wdata),
    .re_i   (in_xfer),
    .raddr_i(handle_index_i),
    .rdata_o(gen_rdata)
  );

  // The free stack stores each freed slot together with its bumped generation, so a
  // create that pops it needs no second, dependent read of the generation table.
  gha_ram #(
    .DEPTH(SLOTS),
    .WIDTH(STK_W)
  ) u_stack_ram (
    .clk_i  (clk_i),
    .we_i   (stk_we),
    .waddr_i(stk_waddr),
    .wdata_i(stk_wdata),
    .re_i   (in_xfer),
    .raddr_i(stk_raddr),
    .rdata_o(stk_rdata)
  );

  // The top of the stack sits one below the depth. With an empty stack this reads an
  // entry that is never used.
  assign stk_raddr = IDX_W'(free_depth_q - CNT_W'(1));
  assign stk_top   = stack_entry_t'(stk_rdata);
  assign slot_rd   = slot_entry_t'(gen_rdata);

  // Next-state logic.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          state_d = ST_EXEC;
        end
      end
      ST_EXEC: begin
        if (exec_go) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Handshake outputs of the sequencer. The execute cycle waits only while the output
  // register still holds a result that the sink is stalling.
  always_comb begin
    in_stall_o = 1'b1;
    exec_go    = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        in_stall_o = 1'b0;
      end
      ST_EXEC: begin
        exec_go = !(out_valid_q && out_stall_i);
      end
      default: begin
        in_stall_o = 1'b1;
      end
    endcase
  end

  assign in_xfer = in_valid_i && !in_stall_o;

  // A handle is alive when its slot has been handed out, is live now, and the stamps
  // agree. Writes land as execute finishes, before the next read can be issued, so the
  // read data is always current and no forwarding is needed. Entries at or above the
  // high-water mark may be unwritten; the range test alone decides those.
  assign hit = ({1'b0, req_idx_q} < high_water_q) && slot_rd.live &&
               (slot_rd.gen == req_gen_q);
  assign gen_next = slot_rd.gen + GEN_W'(1);

  // Execute: decide the result and the write-back from the RAM read data.
  always_comb begin
    free_depth_d = free_depth_q;
    high_water_d = high_water_q;
    live_total_d = live_total_q;
    gen_we       = 1'b0;
    gen_waddr    = req_idx_q;
    gen_wdata    = '{live: 1'b0, gen: gen_next};
    stk_we       = 1'b0;
    stk_waddr    = IDX_W'(free_depth_q);
    stk_wdata    = '{idx: req_idx_q, gen: gen_next};
    res_status   = STATUS_DONE;
    res_index    = req_idx_q;
    res_gen      = req_gen_q;
    res_alive    = 1'b0;

    case (req_mode_q)
      MODE_CREATE: begin
        if (free_depth_q != '0) begin
          // Reuse the most recently freed slot; its stamp is already in the table.
          free_depth_d = free_depth_q - CNT_W'(1);
          gen_we       = exec_go;
          gen_waddr    = stk_top.idx;
          gen_wdata    = '{live: 1'b1, gen: stk_top.gen};
          live_total_d = live_total_q + CNT_W'(1);
          res_index    = stk_top.idx;
          res_gen      = stk_top.gen;
        end else if (high_water_q != CNT_W'(SLOTS)) begin
          // Take a fresh slot at the high-water mark with generation zero.
          gen_we       = exec_go;
          gen_waddr    = IDX_W'(high_water_q);
          gen_wdata    = '{live: 1'b1, gen: '0};
          high_water_d = high_water_q + CNT_W'(1);
          live_total_d = live_total_q + CNT_W'(1);
          res_index    = IDX_W'(high_water_q);
          res_gen      = '0;
        end else begin
          res_status = STATUS_FULL;
        end
      end
      MODE_DESTROY: begin
        if (hit) begin
          res_alive = 1'b1;
          gen_we    = exec_go;
          if (free_depth_q != CNT_W'(SLOTS)) begin
            stk_we       = exec_go;
            free_depth_d = free_depth_q + CNT_W'(1);
          end
          if (live_total_q != '0) begin
            live_total_d = live_total_q - CNT_W'(1);
          end
        end else begin
          res_status = STATUS_DEAD;
        end
      end
      default: begin
        // Check, and the unused mode code, change nothing.
        if (hit) begin
          res_alive = 1'b1;
        end else begin
          res_status = STATUS_DEAD;
        end
      end
    endcase
  end

  // The output register drains on an output transfer and reloads when execute finishes.
  always_comb begin
    out_valid_d = out_valid_q;
    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
    if (exec_go) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      out_valid_q  <= 1'b0;
      free_depth_q <= '0;
      high_water_q <= '0;
      live_total_q <= '0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      if (exec_go) begin
        free_depth_q <= free_depth_d;
        high_water_q <= high_water_d;
        live_total_q <= live_total_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      req_mode_q <= mode_i;
      req_idx_q  <= handle_index_i;
      req_gen_q  <= handle_generation_i;
    end
    if (exec_go) begin
      status_q     <= res_status;
      out_index_q  <= res_index;
      out_gen_q    <= res_gen;
      alive_q      <= res_alive;
      live_count_q <= live_total_d;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign status_o         = status_q;
  assign out_index_o      = out_index_q;
  assign out_generation_o = out_gen_q;
  assign alive_o          = alive_q;
  assign live_count_o     = live_count_q;

  // Every slot below the high-water mark is either live or on the free stack.
  a_slot_balance: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ({1'b0, free_depth_q} + {1'b0, live_total_q}) == {1'b0, high_water_q})
    else $error("free depth plus live count differs from the high-water mark");

  // A stalled result stays put until it transfers.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=>
      (out_valid_o && $stable(out_index_o) && $stable(live_count_o)))
    else $error("stalled result changed before its transfer");

  // A request transfer is always followed by the execute cycle.
  a_exec_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_xfer |=> (state_q == ST_EXEC))
    else $error("request transfer not followed by execute");

  // Finishing execute always presents a result.
  a_result_loaded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    exec_go |=> out_valid_q)
    else $error("execute finished without a result");

endmodule

`default_nettype wire

[tb/tb_generational_handle_allocator_core.sv]
`default_nettype none

// Self-checking bench for the generational handle allocator.
// A queue of pending requests is filled by the stimulus process and drained by a
// clocked driver. Every request that transfers is run through an in-bench allocator
// model, and the reply it predicts is queued. A clocked monitor compares each reply
// transfer, field by field, with the oldest queued reply.
module tb_generational_handle_allocator_core;
  import gha_pkg::*;

  // The block treats the unused mode encoding as a plain liveness check.
  localparam logic [MODE_W-1:0] MODE_SPARE = 2'd3;

  localparam int DIRECTED_PAUSE = 1;
  localparam int RANDOM_ITEMS   = 1150;
  localparam int FILL_END       = 450;  // mostly creates up to here, so the table fills up
  localparam int CHURN_END      = 800;  // balanced traffic around the full point
  localparam int QUIET_ITEMS    = 150;  // no idling on either side for the last items
  localparam int STUCK_LIMIT    = 4000; // cycles without any transfer before giving up
  localparam int SETTLE_CYCLES  = 10;
  localparam int REPORT_CAP     = 200;

  typedef struct packed {
    logic [MODE_W-1:0] mode;
    logic [IDX_W-1:0]  idx;
    logic [GEN_W-1:0]  gen;
  } request_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [IDX_W-1:0]    idx;
    logic [GEN_W-1:0]    gen;
    logic                alive;
    logic [CNT_W-1:0]    live;
  } reply_t;

  // Every block input starts at a known value.
  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic [MODE_W-1:0] mode_i = MODE_CREATE;
  logic [IDX_W-1:0] handle_index_i = '0;
  logic [GEN_W-1:0] handle_generation_i = '0;
  logic out_stall_i = 1'b0;

  logic in_stall_o;
  logic out_valid_o;
  logic [STATUS_W-1:0] status_o;
  logic [IDX_W-1:0] out_index_o;
  logic [GEN_W-1:0] out_generation_o;
  logic alive_o;
  logic [CNT_W-1:0] live_count_o;

  generational_handle_allocator_core u_top (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .in_valid_i         (in_valid_i),
    .in_stall_o         (in_stall_o),
    .mode_i             (mode_i),
    .handle_index_i     (handle_index_i),
    .handle_generation_i(handle_generation_i),
    .out_valid_o        (out_valid_o),
    .out_stall_i        (out_stall_i),
    .status_o           (status_o),
    .out_index_o        (out_index_o),
    .out_generation_o   (out_generation_o),
    .alive_o            (alive_o),
    .live_count_o       (live_count_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  request_t pending_requests[$];
  reply_t expected_replies[$];

  // Model state. Generation stamps and stack entries are only read once written,
  // exactly as in the block, so they need no reset.
  logic [GEN_W-1:0] slot_gen[SLOTS];
  logic [IDX_W-1:0] freed_slots[SLOTS];
  bit slot_in_use[SLOTS];
  int freed_depth = 0;
  int next_fresh = 0;
  int live_handles = 0;

  bit quiet_tail = 1'b0;
  int gap_left = 0;
  int stall_left = 0;
  int mismatches = 0;
  int sent_requests = 0;
  int seen_replies = 0;
  int granted = 0;
  int full_reports = 0;
  int rejected = 0;
  int alive_hits = 0;
  int peak_live = 0;
  int stuck_cycles = 0;

  // A handle is alive when its slot has been handed out at least once, is held
  // right now, and still carries the same generation stamp.
  function automatic bit handle_is_live(logic [IDX_W-1:0] idx, logic [GEN_W-1:0] gen);
    return (int'(idx) < next_fresh) && slot_in_use[idx] && (slot_gen[idx] == gen);
  endfunction

  // Applies one request to the model state and returns the reply the block owes.
  function automatic reply_t predict_allocation(request_t rq);
    reply_t rp;
    logic [IDX_W-1:0] slot;
    bit took;
    rp.status = STATUS_DONE;
    rp.idx = rq.idx;
    rp.gen = rq.gen;
    rp.alive = 1'b0;
    took = 1'b0;
    slot = '0;
    if (rq.mode == MODE_CREATE) begin
      // The most recently freed slot goes out first; otherwise a fresh one.
      if (freed_depth > 0) begin
        freed_depth--;
        slot = freed_slots[freed_depth];
        took = 1'b1;
      end else if (next_fresh < SLOTS) begin
        slot = next_fresh[IDX_W-1:0];
        slot_gen[slot] = '0;
        next_fresh++;
        took = 1'b1;
      end else begin
        rp.status = STATUS_FULL;
      end
      if (took) begin
        slot_in_use[slot] = 1'b1;
        live_handles++;
        rp.idx = slot;
        rp.gen = slot_gen[slot];
      end
    end else if (rq.mode == MODE_DESTROY) begin
      if (handle_is_live(rq.idx, rq.gen)) begin
        rp.alive = 1'b1;
        slot_gen[rq.idx] = slot_gen[rq.idx] + 1'b1;
        slot_in_use[rq.idx] = 1'b0;
        freed_slots[freed_depth] = rq.idx;
        freed_depth++;
        live_handles--;
      end else begin
        rp.status = STATUS_DEAD;
      end
    end else begin
      // Check, and the spare encoding that acts like it.
      if (handle_is_live(rq.idx, rq.gen)) rp.alive = 1'b1;
      else rp.status = STATUS_DEAD;
    end
    rp.live = live_handles[CNT_W-1:0];
    return rp;
  endfunction

  // Looks for a slot that is held right now by probing a few random indices.
  function automatic bit find_live_slot(output int slot);
    slot = 0;
    if (next_fresh == 0) return 1'b0;
    for (int t = 0; t < 16; t++) begin
      slot = $urandom_range(0, next_fresh - 1);
      if (slot_in_use[slot]) return 1'b1;
    end
    return 1'b0;
  endfunction

  // Builds one random request. Destroys and checks mostly name a real handle read
  // from the model; the rest use a wrong stamp, the stamp before the current one of a
  // handed-out slot, or random fields; the first two of these must be rejected.
  function automatic request_t compose_request(int create_pct, int destroy_pct);
    request_t rq;
    int roll;
    int slot;
    int flavor;
    bit hit;
    roll = $urandom_range(0, 99);
    flavor = $urandom_range(0, 99);
    rq.idx = IDX_W'($urandom);
    rq.gen = GEN_W'($urandom);
    hit = find_live_slot(slot);
    if (roll < create_pct) begin
      rq.mode = MODE_CREATE;
    end else begin
      if (roll < create_pct + destroy_pct) rq.mode = MODE_DESTROY;
      else if (roll < 93) rq.mode = MODE_CHECK;
      else rq.mode = MODE_SPARE;
      if (hit && flavor < 75) begin
        rq.idx = IDX_W'(slot);
        rq.gen = slot_gen[slot];
      end else if (hit && flavor < 85) begin
        rq.idx = IDX_W'(slot);
        rq.gen = slot_gen[slot] + GEN_W'($urandom_range(1, (1 << GEN_W) - 1));
      end else if (next_fresh > 0 && flavor < 95) begin
        rq.idx = IDX_W'($urandom_range(0, next_fresh - 1));
        rq.gen = slot_gen[rq.idx] - 1'b1;
      end
    end
    return rq;
  endfunction

  // Sender. A request that transfers is predicted right away; after that the next
  // one is put on the bus unless an idle burst is running. While the block stalls,
  // the payload holds still.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      gap_left = 0;
    end else begin
      if (in_valid_i && !in_stall_o) begin
        expected_replies = {expected_replies, predict_allocation(
          request_t'{mode_i, handle_index_i, handle_generation_i})};
        sent_requests++;
      end
      if (!in_valid_i || !in_stall_o) begin
        if (gap_left > 0) begin
          gap_left--;
          in_valid_i <= 1'b0;
        end else if (!quiet_tail && $urandom_range(0, 11) == 0) begin
          // Start an idle burst that includes this cycle and lasts while gap_left counts down.
          gap_left = $urandom_range(0, 16);
          in_valid_i <= 1'b0;
        end else if (pending_requests.size() > 0) begin
          request_t rq;
          rq = pending_requests.pop_front();
          mode_i <= rq.mode;
          handle_index_i <= rq.idx;
          handle_generation_i <= rq.gen;
          in_valid_i <= 1'b1;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  task automatic compare_field(string what, int unsigned want, int unsigned got);
    if (want != got) begin
      mismatches++;
      if (mismatches <= REPORT_CAP)
        $display("%0t: %s mismatch, expected %0d, actual %0d", $time, what, want, got);
    end
  endtask

  // Receiver. Checks each reply transfer against the oldest prediction and plays
  // out stall bursts on the reply side.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
      stall_left = 0;
    end else begin
      if (out_valid_o && !out_stall_i) begin
        seen_replies++;
        if (expected_replies.size() == 0) begin
          mismatches++;
          $display("%0t: reply transfer with no request waiting, status %0d index %0d",
                   $time, status_o, out_index_o);
        end else begin
          reply_t want;
          want = expected_replies.pop_front();
          compare_field("status", want.status, status_o);
          compare_field("out_index", want.idx, out_index_o);
          compare_field("out_generation", want.gen, out_generation_o);
          compare_field("alive", want.alive, alive_o);
          compare_field("live_count", want.live, live_count_o);
          if (want.status == STATUS_FULL) full_reports++;
          if (want.status == STATUS_DEAD) rejected++;
          if (want.alive) alive_hits++;
          if (want.status == STATUS_DONE && !want.alive) granted++;
          if (int'(want.live) > peak_live) peak_live = want.live;
        end
      end
      if (stall_left > 0) begin
        stall_left--;
        out_stall_i <= 1'b1;
      end else if (!quiet_tail && $urandom_range(0, 9) == 0) begin
        stall_left = $urandom_range(0, 16);
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= 1'b0;
      end
    end
  end

  // Watchdog: any transfer on either side counts as progress.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
        stuck_cycles = 0;
      end else begin
        stuck_cycles++;
        if (stuck_cycles >= STUCK_LIMIT) begin
          $display("%0t: no transfer for %0d cycles, %0d replies outstanding",
                   $time, STUCK_LIMIT, expected_replies.size());
          $display("FAIL");
          $finish;
        end
      end
    end
  end

  // Holds the stimulus process back until every queued request has gone out and every reply owed so far has arrived.
  task automatic wait_until_quiet();
    while (pending_requests.size() != 0 || in_valid_i || expected_replies.size() != 0)
      @(negedge clk_i);
  endtask

  task automatic queue_request(logic [MODE_W-1:0] mode, logic [IDX_W-1:0] idx,
                               logic [GEN_W-1:0] gen);
    pending_requests = {pending_requests, request_t'{mode, idx, gen}};
  endtask

  initial begin
    int create_pct;
    int destroy_pct;
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed opening. Nothing is allocated yet, so the first two handles are
    // out of range and must be rejected without touching any state.
    queue_request(MODE_CHECK, '1, '1);
    queue_request(MODE_DESTROY, '0, '0);
    // Two fresh slots come from the high-water mark with stamp zero; the fields
    // of a create are ignored, so drive them at their extremes.
    queue_request(MODE_CREATE, '1, '1);
    queue_request(MODE_CREATE, '0, '0);
    queue_request(MODE_CHECK, 8'd0, 16'd0);
    queue_request(MODE_CHECK, 8'd0, '1);        // right slot, wrong stamp
    queue_request(MODE_SPARE, 8'd0, 16'd0);     // spare mode acts as a check
    queue_request(MODE_DESTROY, 8'd0, 16'd0);   // slot 0 now carries stamp 1
    queue_request(MODE_DESTROY, 8'd0, 16'd0);   // double destroy is stale
    // A guessed handle naming the freed slot with its new stamp is not alive.
    queue_request(MODE_CHECK, 8'd0, 16'd1);
    queue_request(MODE_DESTROY, 8'd0, 16'd1);
    queue_request(MODE_CREATE, '0, '0);         // reuses slot 0 with stamp 1
    queue_request(MODE_DESTROY, 8'd1, 16'd0);
    queue_request(MODE_DESTROY, 8'd0, 16'd1);
    // Last freed goes out first: slot 0 with stamp 2, then slot 1 with stamp 1.
    queue_request(MODE_CREATE, '1, '0);
    queue_request(MODE_CREATE, '0, '1);
    queue_request(MODE_CHECK, 8'd2, 16'd0);     // at the high-water mark
    queue_request(MODE_SPARE, '1, 16'd0);
    if (DIRECTED_PAUSE) wait_until_quiet();

    // Random traffic: fill the table so that creates report full, churn around the
    // full point, then drain. The sender pauses for all replies between phases.
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      while (pending_requests.size() >= 4) @(negedge clk_i);
      if (n == FILL_END || n == CHURN_END) wait_until_quiet();
      if (n >= RANDOM_ITEMS - QUIET_ITEMS) quiet_tail = 1'b1;
      if (n < FILL_END) begin
        create_pct = 75;
        destroy_pct = 12;
      end else if (n < CHURN_END) begin
        create_pct = 42;
        destroy_pct = 35;
      end else begin
        create_pct = 12;
        destroy_pct = 65;
      end
      pending_requests = {pending_requests, compose_request(create_pct, destroy_pct)};
    end

    wait_until_quiet();
    repeat (SETTLE_CYCLES) @(posedge clk_i);

    $display("Requests sent %0d, replies checked %0d: %0d slots handed out, %0d full reports,",
             sent_requests, seen_replies, granted, full_reports);
    $display("%0d live handles confirmed, %0d stale handles rejected, peak live count %0d.",
             alive_hits, rejected, peak_live);
    if (mismatches == 0) begin
      $display("PASS");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("FAIL");
    end
    $finish;
  end

endmodule

`default_nettype wire
